/* rtl/core/zspf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zspf_pkg
// Shared types and constants of the zero-suppressed pixel frame decoder.
// ----------------------------------------------------------------------------
package zspf_pkg;

   localparam int ROW_W   = 11;
   localparam int COL_W   = 11;
   localparam int PIX_W   = 12;
   localparam int RUN_W   = 2;
   localparam int PROW_W  = 10;
   localparam int ELEM_W  = 17;

   // Pivot row: ((pivot >> 4) + 4) mod 576, the mod done by reciprocal multiply
   localparam logic [3:0]  PIVOT_OFFSET_ROWS = 4'd4;     // 64 / 16
   localparam logic [12:0] PIVOT_RECIP       = 13'd7282; // ceil(2^22 / 576)
   localparam int          PIVOT_SHIFT       = 22;

   // One queue entry: the runs decoded from one payload word
   typedef struct packed {
      logic               run0_valid;
      logic [COL_W-1:0]   run0_column;
      logic [RUN_W-1:0]   run0_length;
      logic               run1_valid;
      logic [COL_W-1:0]   run1_column;
      logic [RUN_W-1:0]   run1_length;
      logic [ROW_W-1:0]   row;
      logic [PROW_W-1:0]  pivot_row;
      logic               frame;
   } zspf_entry_type;

endpackage

/* rtl/core/zs_pixel_frame_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zs_pixel_frame_decoder
// Zero-suppressed pixel frame decoder: line headers and state runs in,
// hit pixels out.
//
//   channel  direction  transaction
//   req_     in         one 32-bit payload word, frame info on frame start
//   rsp_     out        one hit pixel
//
// The front end decodes both elements of a word in the accept cycle and
// takes a word every cycle while the run queue has room.
// The back end sends one pixel per cycle while the response side is ready;
// a word yields up to eight pixels, and words without hits are not queued.
// Either side stalls on its own through the queue of QUEUE_DEPTH entries.
// Reset clears frame state to idle (decoding stopped) and empties the queue.
// ----------------------------------------------------------------------------
module zs_pixel_frame_decoder
   import zspf_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_data_word,
   input  logic               req_frame_start,
   input  logic [15:0]        req_frame_words,
   input  logic [15:0]        req_pivot_value,
   input  logic               req_frame_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [PIX_W-1:0]   rsp_pixel_column,
   output logic [ROW_W-1:0]   rsp_pixel_row,
   output logic               rsp_after_pivot,
   output logic               rsp_pixel_frame,
   output logic               rsp_last_of_run
);

   logic            queue_full;
   logic            push_valid;
   zspf_entry_type  push_entry;
   logic            head_valid;
   zspf_entry_type  head_entry;
   logic            pop;

   zspf_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_word   (req_data_word),
      .req_frame_start (req_frame_start),
      .req_frame_words (req_frame_words),
      .req_pivot_value (req_pivot_value),
      .req_frame_index (req_frame_index),
      .queue_full      (queue_full),
      .push_valid      (push_valid),
      .push_entry      (push_entry)
   );

   zspf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   zspf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_entry       (head_entry),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_column (rsp_pixel_column),
      .rsp_pixel_row    (rsp_pixel_row),
      .rsp_after_pivot  (rsp_after_pivot),
      .rsp_pixel_frame  (rsp_pixel_frame),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

/* rtl/core/zspf_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zspf_front
// Accepts payload words, tracks frame and line header state, and pushes the
// state runs of each word into the run queue.
// ----------------------------------------------------------------------------
module zspf_front
   import zspf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [31:0]          req_data_word,
   input  logic                 req_frame_start,
   input  logic [15:0]          req_frame_words,
   input  logic [15:0]          req_pivot_value,
   input  logic                 req_frame_index,
   input  logic                 queue_full,
   output logic                 push_valid,
   output zspf_entry_type       push_entry
);

   typedef struct packed {
      logic [ELEM_W-1:0] left;
      logic [3:0]        pending;
      logic [ROW_W-1:0]  row;
      logic              stopped;
   } zspf_dec_type;

   typedef struct packed {
      zspf_dec_type      st;
      logic              hit;
      logic [COL_W-1:0]  column;
      logic [RUN_W-1:0]  length;
   } zspf_take_type;

   // Decode one 16-bit element against the running line state
   function automatic zspf_take_type take_element(input zspf_dec_type st,
                                                  input logic [15:0] elem);
      zspf_take_type r;
      logic [4:0]    need;
      r        = '0;
      r.st     = st;
      r.column = elem[12:2];
      r.length = elem[1:0];
      need     = {1'b0, elem[3:0]} + 5'd1;
      if (st.stopped || st.left == '0) begin
         r.st.left    = '0;
         r.st.pending = '0;
         r.st.stopped = 1'b1;
      end else if (st.pending != '0) begin
         r.hit        = 1'b1;
         r.st.pending = st.pending - 4'd1;
         r.st.left    = st.left - 17'd1;
      end else if (st.left == 17'd1 || {12'b0, need} > st.left) begin
         // header as last element, or its states overrun the frame
         r.st.left    = '0;
         r.st.pending = '0;
         r.st.stopped = 1'b1;
      end else begin
         r.st.row     = elem[14:4];
         r.st.pending = elem[3:0];
         r.st.left    = st.left - 17'd1;
      end
      return r;
   endfunction

   zspf_dec_type       dec_ff, dec_in;
   logic [PROW_W-1:0]  pivot_row_ff, pivot_row_in;
   logic               frame_ff, frame_in;

   zspf_dec_type       st0;
   zspf_take_type      t0, t1;
   logic               accept;

   logic [12:0]        piv_sum;
   logic [25:0]        piv_prod;
   logic [2:0]         piv_quot;
   logic [12:0]        piv_rem;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // Pivot row from raw pivot value
   always_comb begin
      piv_sum  = {1'b0, req_pivot_value[15:4]} + {9'b0, PIVOT_OFFSET_ROWS};
      piv_prod = piv_sum * PIVOT_RECIP;
      piv_quot = piv_prod[PIVOT_SHIFT +: 3];
      piv_rem  = piv_sum - ({1'b0, piv_quot, 9'b0} + {4'b0, piv_quot, 6'b0});
   end

   // Frame start load, then both elements low half first
   always_comb begin
      st0          = dec_ff;
      pivot_row_in = pivot_row_ff;
      frame_in     = frame_ff;
      if (req_frame_start) begin
         st0.left     = {req_frame_words, 1'b0};
         st0.pending  = '0;
         st0.stopped  = (req_frame_words == '0);
         pivot_row_in = piv_rem[PROW_W-1:0];
         frame_in     = req_frame_index;
      end
      t0     = take_element(st0, req_data_word[15:0]);
      t1     = take_element(t0.st, req_data_word[31:16]);
      dec_in = t1.st;

      push_entry.run0_valid  = t0.hit;
      push_entry.run0_column = t0.column;
      push_entry.run0_length = t0.length;
      push_entry.run1_valid  = t1.hit;
      push_entry.run1_column = t1.column;
      push_entry.run1_length = t1.length;
      push_entry.row         = t0.st.row;
      push_entry.pivot_row   = pivot_row_in;
      push_entry.frame       = frame_in;
      push_valid             = accept && (t0.hit || t1.hit);
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff.left    <= '0;
         dec_ff.pending <= '0;
         dec_ff.row     <= '0;
         dec_ff.stopped <= 1'b1;
         pivot_row_ff   <= '0;
         frame_ff       <= 1'b0;
      end else if (accept) begin
         dec_ff       <= dec_in;
         pivot_row_ff <= pivot_row_in;
         frame_ff     <= frame_in;
      end
   end

endmodule

/* rtl/core/zspf_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zspf_queue
// Small FIFO of decoded run entries between the front and back ends.
// ----------------------------------------------------------------------------
module zspf_queue
   import zspf_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   input  zspf_entry_type  push_entry,
   output logic            full,
   output logic            head_valid,
   output zspf_entry_type  head_entry,
   input  logic            pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   zspf_entry_type     slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* rtl/core/zspf_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zspf_back
// Expands queued runs into pixels, one pixel per cycle while the output is
// not stalled, into a registered result stage.
// ----------------------------------------------------------------------------
module zspf_back
   import zspf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  zspf_entry_type     head_entry,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [PIX_W-1:0]   rsp_pixel_column,
   output logic [ROW_W-1:0]   rsp_pixel_row,
   output logic               rsp_after_pivot,
   output logic               rsp_pixel_frame,
   output logic               rsp_last_of_run
);

   logic               sel_ff, sel_in;
   logic [RUN_W-1:0]   offs_ff, offs_in;
   logic               valid_ff, valid_in;
   logic [PIX_W-1:0]   column_ff, column_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic               piv_ff, piv_in;
   logic               frame_ff, frame_in;
   logic               last_ff, last_in;

   logic               cur_sel;
   logic [COL_W-1:0]   cur_column;
   logic [RUN_W-1:0]   cur_length;
   logic               run_done;
   logic               load;

   // Pick the active run of the head entry
   always_comb begin
      cur_sel    = sel_ff || !head_entry.run0_valid;
      cur_column = cur_sel ? head_entry.run1_column : head_entry.run0_column;
      cur_length = cur_sel ? head_entry.run1_length : head_entry.run0_length;
      run_done   = (offs_ff == cur_length);
      load       = head_valid && (!valid_ff || rsp_ready);
      pop        = load && run_done && (cur_sel || !head_entry.run1_valid);
   end

   // Next pixel and walk state
   always_comb begin
      sel_in    = sel_ff;
      offs_in   = offs_ff;
      valid_in  = valid_ff && !rsp_ready;
      column_in = column_ff;
      row_in    = row_ff;
      piv_in    = piv_ff;
      frame_in  = frame_ff;
      last_in   = last_ff;
      if (load) begin
         valid_in  = 1'b1;
         column_in = {1'b0, cur_column} + {{(PIX_W-RUN_W){1'b0}}, offs_ff};
         row_in    = head_entry.row;
         piv_in    = (head_entry.row >= {1'b0, head_entry.pivot_row});
         frame_in  = head_entry.frame;
         last_in   = pop;
         if (!run_done) begin
            offs_in = offs_ff + 1'b1;
         end else begin
            offs_in = '0;
            sel_in  = !pop;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= 1'b0;
         offs_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         sel_ff   <= sel_in;
         offs_ff  <= offs_in;
         valid_ff <= valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      column_ff <= column_in;
      row_ff    <= row_in;
      piv_ff    <= piv_in;
      frame_ff  <= frame_in;
      last_ff   <= last_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_pixel_column = column_ff;
   assign rsp_pixel_row    = row_ff;
   assign rsp_after_pivot  = piv_ff;
   assign rsp_pixel_frame  = frame_ff;
   assign rsp_last_of_run  = last_ff;

endmodule
